### rtl/fbw_pkg.sv
// ----------------------------------------------------------------------------
// fbw_pkg: shared types and constants
// Transaction payloads, the clamped configuration and the command that
// passes from the front part to the back part of the window reassembler.
// ----------------------------------------------------------------------------
package fbw_pkg;

  localparam int MAX_PER_SIDE = 32;
  localparam int MAX_BUFFERS  = 16;
  localparam int SLOTS        = 2 * MAX_PER_SIDE;
  localparam int RESTART_SPAN = 128;
  localparam int BUF_W        = $clog2(MAX_BUFFERS);
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int SPAN_W       = $clog2(RESTART_SPAN);

  localparam logic [7:0] CFG_DATA_PER_BLOCK = 8'd0;
  localparam logic [7:0] CFG_FEC_PER_BLOCK  = 8'd1;
  localparam logic [7:0] CFG_BUFFERS_IN_USE = 8'd2;

  typedef struct packed {
    logic [31:0] seq_no;
    logic        crc_ok;
  } in_item_t;

  typedef struct packed {
    logic [31:0] retired_block;
    logic [4:0]  erased_data_index;
    logic [4:0]  fec_index;
    logic [5:0]  data_missing;
    logic [5:0]  data_corrupt;
    logic [5:0]  fec_missing;
    logic [5:0]  fec_corrupt;
    logic        recon_failed;
    logic [31:0] data_emit_mask;
    logic [31:0] restart_count;
    logic        last;
  } out_item_t;

  // Clamped register values.
  typedef struct packed {
    logic [5:0] nd;
    logic [5:0] nf;
    logic [4:0] nb;
  } cfg_t;

  typedef struct packed {
    logic [31:0]       blk;
    logic [SLOT_W-1:0] slot;
    logic              crc;
  } cmd_t;

endpackage

### rtl/fbw_front.sv
// ----------------------------------------------------------------------------
// fbw_front: sequence number splitter
// Divides each sequence number by the block length one bit a cycle and
// queues block, slot and CRC flag for the back part.
// ----------------------------------------------------------------------------
module fbw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  fbw_pkg::cfg_t    cfg,
  input  logic             in_push,
  output logic             in_full,
  input  fbw_pkg::in_item_t in_data,
  output logic             cmd_valid,
  output fbw_pkg::cmd_t    cmd_data,
  input  logic             cmd_pop
);
  import fbw_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        crc_r, crc_nxt;
  logic [6:0]  n;
  logic [7:0]  trial;

  cmd_t        q_mem [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        q_push, q_full;

  assign n      = {1'b0, cfg.nd} + {1'b0, cfg.nf};
  assign trial  = {rem_r, quo_r[31]};
  assign q_full = (cnt_r == 2'd2);
  assign in_full = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    crc_nxt   = crc_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          quo_nxt   = in_data.seq_no;
          crc_nxt   = in_data.crc_ok;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, n}) begin
          rem_nxt = 7'(trial - {1'b0, n});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[6:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    crc_r  <= crc_nxt;
  end

  // Two-entry command queue towards the back part.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= !wp_r;
      end
      if (cmd_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, q_push} - {1'b0, cmd_pop});
    end
    if (q_push) begin
      q_mem[wp_r] <= '{blk: quo_r, slot: rem_r[SLOT_W-1:0], crc: crc_r};
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_mem[rp_r];

endmodule

### rtl/fbw_back.sv
// ----------------------------------------------------------------------------
// fbw_back: window bookkeeping and retirement
// Claims buffers, stores slot flags and retires blocks into pairing and
// report transactions.
// ----------------------------------------------------------------------------
module fbw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fbw_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  input  fbw_pkg::cmd_t     cmd_data,
  output logic              cmd_pop,
  output logic              res_push,
  output fbw_pkg::out_item_t res_data,
  input  logic              res_room
);
  import fbw_pkg::*;

  typedef enum logic [10:0] {
    B_IDLE   = 11'b00000000001,
    B_EVAL   = 11'b00000000010,
    B_PICK   = 11'b00000000100,
    B_RRD    = 11'b00000001000,
    B_GATHER = 11'b00000010000,
    B_SETUP  = 11'b00000100000,
    B_WALK   = 11'b00001000000,
    B_REPORT = 11'b00010000000,
    B_CLAIM  = 11'b00100000000,
    B_LOOK   = 11'b01000000000,
    B_MOD    = 11'b10000000000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic    srd_r, srd_nxt;

  cmd_t             cmd_r, cmd_nxt;
  logic [BUF_W-1:0] i_r, i_nxt, pick_r, pick_nxt, hit_r, hit_nxt;
  logic [31:0]      minb_r, minb_nxt;
  logic [MAX_BUFFERS-1:0] used_r, used_nxt, rowv_r, rowv_nxt;
  logic [31:0]      blk_r [MAX_BUFFERS];
  logic [32:0]      high_r, high_nxt;
  logic [31:0]      rcnt_r, rcnt_nxt;

  logic [MAX_PER_SIDE-1:0] dv_r, dv_nxt, dg_r, dg_nxt, fv_r, fv_nxt, fg_r, fg_nxt;
  logic [5:0] k_r, k_nxt;
  logic       fph_r, fph_nxt;
  logic [5:0] dm_r, dm_nxt, dc_r, dc_nxt, fm_r, fm_nxt, fc_r, fc_nxt;
  logic [5:0] wdm_r, wdm_nxt, gf_r, gf_nxt, good_r, good_nxt, di_r, di_nxt, fi_r, fi_nxt;

  logic [SLOTS-1:0] rcv_mem [MAX_BUFFERS];
  logic [SLOTS-1:0] cg_mem  [MAX_BUFFERS];
  logic [SLOTS-1:0] rcv_q, cg_q, rv_row, cg_row, rv_w, cg_w;
  logic [BUF_W-1:0] mem_addr;
  logic             mem_we;

  logic [33:0] blk_x, hi_x, span_x;
  logic        restart, newer, last_i, failed;
  logic [6:0]  s_d, s_f;
  logic [5:0]  s_sel;
  logic [31:0] mask;

  assign blk_x   = {2'b00, cmd_r.blk};
  assign hi_x    = {high_r[32], high_r};
  assign span_x  = 34'({cfg.nb, {SPAN_W{1'b0}}});
  assign restart = $signed(blk_x + span_x) < $signed(hi_x);
  assign newer   = $signed(blk_x) > $signed(hi_x);
  assign last_i  = ({1'b0, i_r} == 5'(cfg.nb - 5'd1));

  // Slot of data k and of FEC k in the interleaved layout.
  assign s_d   = {1'b0, k_r} + ((k_r < cfg.nf) ? {1'b0, k_r} : {1'b0, cfg.nf});
  assign s_f   = {1'b0, k_r} + (((k_r + 6'd1) < cfg.nd) ? {1'b0, 6'(k_r + 6'd1)} : {1'b0, cfg.nd});
  assign s_sel = fph_r ? s_f[5:0] : s_d[5:0];

  assign rv_row = rowv_r[mem_addr] ? rcv_q : '0;
  assign cg_row = rowv_r[mem_addr] ? cg_q  : '0;

  assign failed = ({1'b0, dm_r} + {1'b0, dc_r}) > {1'b0, good_r};
  always_comb begin
    for (int k = 0; k < MAX_PER_SIDE; k++) begin
      mask[k] = (6'(k) < cfg.nd) && (!failed || dv_r[k]);
    end
  end

  assign mem_addr = (state_r == B_MOD || state_r == B_LOOK) ? hit_r : pick_r;
  assign cmd_pop  = (state_r == B_IDLE) && cmd_valid;

  always_comb begin
    rv_w = rv_row;
    cg_w = cg_row;
    if (!cg_row[cmd_r.slot]) begin
      rv_w[cmd_r.slot] = 1'b1;
      cg_w[cmd_r.slot] = cmd_r.crc;
    end
  end

  always_comb begin
    state_nxt = state_r;
    srd_nxt   = 1'b0;
    cmd_nxt = cmd_r;   i_nxt = i_r;     pick_nxt = pick_r; hit_nxt = hit_r;
    minb_nxt = minb_r; used_nxt = used_r; rowv_nxt = rowv_r;
    high_nxt = high_r; rcnt_nxt = rcnt_r;
    dv_nxt = dv_r; dg_nxt = dg_r; fv_nxt = fv_r; fg_nxt = fg_r;
    k_nxt = k_r; fph_nxt = fph_r;
    dm_nxt = dm_r; dc_nxt = dc_r; fm_nxt = fm_r; fc_nxt = fc_r;
    wdm_nxt = wdm_r; gf_nxt = gf_r; good_nxt = good_r; di_nxt = di_r; fi_nxt = fi_r;
    mem_we   = 1'b0;
    res_push = 1'b0;
    res_data = '0;
    res_data.retired_block = minb_r;
    res_data.restart_count = rcnt_r;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd_data;
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        i_nxt = '0;
        if ((newer || restart) && cmd_r.crc) begin
          if (restart) begin
            rcnt_nxt = rcnt_r + 32'd1;
            for (int b = 0; b < MAX_BUFFERS; b++) begin
              if (5'(b) < cfg.nb) begin
                used_nxt[b] = 1'b0;
                rowv_nxt[b] = 1'b0;
              end
            end
          end
          state_nxt = B_PICK;
        end else begin
          state_nxt = B_LOOK;
        end
      end
      B_PICK: begin
        if (!used_r[i_r]) begin
          pick_nxt  = i_r;
          state_nxt = B_CLAIM;
        end else begin
          if (i_r == '0 || blk_r[i_r] < minb_r) begin
            minb_nxt = blk_r[i_r];
            pick_nxt = i_r;
          end
          if (last_i) begin
            state_nxt = B_RRD;
          end
          i_nxt = i_r + 1'b1;
        end
      end
      B_RRD: begin
        k_nxt = '0; fph_nxt = 1'b0;
        dm_nxt = '0; dc_nxt = '0; fm_nxt = '0; fc_nxt = '0;
        state_nxt = B_GATHER;
      end
      B_GATHER: begin
        k_nxt = k_r + 6'd1;
        if (!fph_r) begin
          dv_nxt[k_r[4:0]] = rv_row[s_sel];
          dg_nxt[k_r[4:0]] = cg_row[s_sel];
          if (!rv_row[s_sel]) dm_nxt = dm_r + 6'd1;
          else if (!cg_row[s_sel]) dc_nxt = dc_r + 6'd1;
          if (k_r == 6'(cfg.nd - 6'd1)) begin
            k_nxt   = '0;
            fph_nxt = 1'b1;
            if (cfg.nf == '0) state_nxt = B_SETUP;
          end
        end else begin
          fv_nxt[k_r[4:0]] = rv_row[s_sel];
          fg_nxt[k_r[4:0]] = cg_row[s_sel];
          if (!rv_row[s_sel]) fm_nxt = fm_r + 6'd1;
          else if (!cg_row[s_sel]) fc_nxt = fc_r + 6'd1;
          if (k_r == 6'(cfg.nf - 6'd1)) state_nxt = B_SETUP;
        end
      end
      B_SETUP: begin
        wdm_nxt  = dm_r;
        good_nxt = 6'(cfg.nf - fm_r - fc_r);
        gf_nxt   = 6'(cfg.nf - fm_r - fc_r);
        di_nxt   = '0;
        fi_nxt   = '0;
        state_nxt = B_WALK;
      end
      B_WALK: begin
        if (di_r < cfg.nd && fi_r < cfg.nf) begin
          if (dv_r[di_r[4:0]] && dg_r[di_r[4:0]]) begin
            di_nxt = di_r + 6'd1;
          end else if (dv_r[di_r[4:0]] && gf_r <= wdm_r) begin
            di_nxt = di_r + 6'd1;
          end else if (!fv_r[fi_r[4:0]]) begin
            fi_nxt = fi_r + 6'd1;
          end else if (!fg_r[fi_r[4:0]] && wdm_r > gf_r) begin
            fi_nxt = fi_r + 6'd1;
          end else if (res_room) begin
            res_push = 1'b1;
            res_data.erased_data_index = di_r[4:0];
            res_data.fec_index         = fi_r[4:0];
            if (!dv_r[di_r[4:0]]) wdm_nxt = wdm_r - 6'd1;
            if (fg_r[fi_r[4:0]]) gf_nxt = gf_r - 6'd1;
            di_nxt = di_r + 6'd1;
            fi_nxt = fi_r + 6'd1;
          end
        end else begin
          state_nxt = B_REPORT;
        end
      end
      B_REPORT: begin
        res_data.data_missing   = dm_r;
        res_data.data_corrupt   = dc_r;
        res_data.fec_missing    = fm_r;
        res_data.fec_corrupt    = fc_r;
        res_data.recon_failed   = failed;
        res_data.data_emit_mask = mask;
        res_data.last           = 1'b1;
        if (res_room) begin
          res_push  = 1'b1;
          state_nxt = B_CLAIM;
        end
      end
      B_CLAIM: begin
        used_nxt[pick_r] = 1'b1;
        rowv_nxt[pick_r] = 1'b0;
        high_nxt = {1'b0, cmd_r.blk};
        i_nxt    = '0;
        state_nxt = B_LOOK;
      end
      B_LOOK: begin
        if (used_r[i_r] && blk_r[i_r] == cmd_r.blk) begin
          hit_nxt   = i_r;
          srd_nxt   = 1'b1;
          state_nxt = B_MOD;
        end else if (last_i) begin
          state_nxt = B_IDLE;
        end
        i_nxt = i_r + 1'b1;
      end
      B_MOD: begin
        // Waits here for the registered row read of the hit buffer, then writes the row.
        if (!srd_r) begin
          mem_we         = 1'b1;
          rowv_nxt[hit_r] = 1'b1;
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      srd_r   <= 1'b0;
      used_r  <= '0;
      rowv_r  <= '0;
      high_r  <= '1;
      rcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      srd_r   <= srd_nxt;
      used_r  <= used_nxt;
      rowv_r  <= rowv_nxt;
      high_r  <= high_nxt;
      rcnt_r  <= rcnt_nxt;
    end
    cmd_r <= cmd_nxt;  i_r <= i_nxt;  pick_r <= pick_nxt;  hit_r <= hit_nxt;
    minb_r <= minb_nxt;
    dv_r <= dv_nxt; dg_r <= dg_nxt; fv_r <= fv_nxt; fg_r <= fg_nxt;
    k_r <= k_nxt; fph_r <= fph_nxt;
    dm_r <= dm_nxt; dc_r <= dc_nxt; fm_r <= fm_nxt; fc_r <= fc_nxt;
    wdm_r <= wdm_nxt; gf_r <= gf_nxt; good_r <= good_nxt; di_r <= di_nxt; fi_r <= fi_nxt;
    if (state_r == B_CLAIM) begin
      blk_r[pick_r] <= cmd_r.blk;
    end
  end

  // Slot flag rows, one per buffer; a row whose valid bit is clear reads as zero.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rcv_mem[hit_r] <= rv_w;
      cg_mem[hit_r]  <= cg_w;
    end
    rcv_q <= rcv_mem[mem_addr];
    cg_q  <= cg_mem[mem_addr];
  end

endmodule

### rtl/fec_block_window_reassembler.sv
// ----------------------------------------------------------------------------
// fec_block_window_reassembler: FEC block reassembly window
// Tracks received and CRC-good slots per block and retires blocks into
// erasure pairings and a final report.
// ----------------------------------------------------------------------------
// Each accepted transaction is split into block and slot by a bit-serial
// divider in the front part, which accepts no new transaction until it has
// queued the last one. A two-entry queue then feeds the back part, which
// scans the buffer window one buffer a cycle. A packet that retires a block
// adds a scan of the window for the oldest buffer, a gather pass over the
// data and FEC slots, set-up, a pairing walk, the report and the claim of
// the freed buffer, and it waits whenever the two-entry result queue is
// full. Slot flags live in one row per buffer with a valid bit each, so
// there is no clearing pass after reset.
// Configuration registers: 0 data_per_block, 1 fec_per_block,
// 2 buffers_in_use; other indexes are ignored and values are clamped to
// their legal ranges. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module fec_block_window_reassembler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fbw_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output fbw_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import fbw_pkg::*;

  logic [5:0] d_r, f_r;
  logic [4:0] b_r;
  cfg_t       cfg;
  logic       cmd_valid, cmd_pop, res_push, res_room;
  cmd_t       cmd_data;
  out_item_t  res_data;
  out_item_t  oq_mem [2];
  logic       owp_r, orp_r, opop;
  logic [1:0] ocnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= 6'd8;
      f_r <= 6'd4;
      b_r <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DATA_PER_BLOCK: d_r <= cfg_data[5:0];
        CFG_FEC_PER_BLOCK:  f_r <= cfg_data[5:0];
        CFG_BUFFERS_IN_USE: b_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers to the supported ranges.
  assign cfg.nd = (d_r == 6'd0) ? 6'd1 : ((d_r > 6'(MAX_PER_SIDE)) ? 6'(MAX_PER_SIDE) : d_r);
  assign cfg.nf = (f_r > 6'(MAX_PER_SIDE)) ? 6'(MAX_PER_SIDE) : f_r;
  assign cfg.nb = (b_r == 5'd0) ? 5'd1 : ((b_r > 5'(MAX_BUFFERS)) ? 5'(MAX_BUFFERS) : b_r);

  fbw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  fbw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_room  (res_room)
  );

  // Two-entry result queue; the back part stalls while it is full.
  assign res_room  = (ocnt_r != 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign opop      = out_pop && !out_empty;
  assign out_data  = oq_mem[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (res_push) begin
        owp_r <= !owp_r;
      end
      if (opop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= 2'(ocnt_r + {1'b0, res_push} - {1'b0, opop});
    end
    if (res_push) begin
      oq_mem[owp_r] <= res_data;
    end
  end

endmodule

### tb/sv/fbw_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fbw_scoreboard: result checker for the FEC block window reassembler
// Watches the input, result and register channels, keeps its own copy of
// the reassembly window and compares every result with the oldest one due.
// ----------------------------------------------------------------------------
module fbw_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  fbw_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  fbw_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 results_due,
  output int                 results_checked
);
  import fbw_pkg::*;

  logic [5:0]  reg_data;
  logic [5:0]  reg_fec;
  logic [4:0]  reg_bufs;
  logic [31:0] win_block [MAX_BUFFERS];
  bit          win_used  [MAX_BUFFERS];
  bit          slot_rx   [MAX_BUFFERS][SLOTS];
  bit          slot_good [MAX_BUFFERS][SLOTS];
  longint      top_block;
  logic [31:0] restarts;
  out_item_t   due_results[$];

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic clear_slots(int b);
    for (int s = 0; s < SLOTS; s++) begin
      slot_rx[b][s]   = 0;
      slot_good[b][s] = 0;
    end
  endtask

  task automatic reset_window();
    reg_data  = 6'd8;
    reg_fec   = 6'd4;
    reg_bufs  = 5'd1;
    top_block = -1;
    restarts  = '0;
    for (int b = 0; b < MAX_BUFFERS; b++) begin
      win_block[b] = '0;
      win_used[b]  = 0;
      clear_slots(b);
    end
    due_results.delete();
  endtask

  // Sorts the interleaved slots of buffer b, queues one pairing per erased
  // data slot that a usable FEC slot covers, then the block report.
  task automatic retire_block(int b, int nd, int nf);
    bit          dv[MAX_PER_SIDE], dg[MAX_PER_SIDE], fv[MAX_PER_SIDE], fg[MAX_PER_SIDE];
    int          dm, dc, fm, fc, good, dmc, dcc, gf, di, fi, s;
    bit          failed;
    logic [31:0] mask;
    out_item_t   r;
    dm = 0; dc = 0; fm = 0; fc = 0;
    for (int k = 0; k < nd; k++) begin
      s = k + (k < nf ? k : nf);
      dv[k] = slot_rx[b][s];
      dg[k] = slot_good[b][s];
      if (!dv[k]) dm++;
      else if (!dg[k]) dc++;
    end
    for (int k = 0; k < nf; k++) begin
      s = k + (k + 1 < nd ? k + 1 : nd);
      fv[k] = slot_rx[b][s];
      fg[k] = slot_good[b][s];
      if (!fv[k]) fm++;
      else if (!fg[k]) fc++;
    end
    good = nf - fm - fc;
    dmc = dm; dcc = dc; gf = good;
    di = 0; fi = 0;
    while (di < nd && fi < nf) begin
      if (dv[di] && dg[di]) begin
        di++;
      end else if (dv[di] && !dg[di] && gf <= dm) begin
        di++;
      end else if (!fv[fi]) begin
        fi++;
      end else if (!fg[fi] && dm > gf) begin
        fi++;
      end else begin
        if (!dv[di]) dm--;
        else if (!dg[di]) dc--;
        if (fg[fi]) gf--;
        r = '0;
        r.retired_block     = win_block[b];
        r.erased_data_index = di[4:0];
        r.fec_index         = fi[4:0];
        r.restart_count     = restarts;
        due_results.push_back(r);
        di++;
        fi++;
      end
    end
    failed = (dmc + dcc) > good;
    mask = '0;
    for (int k = 0; k < nd; k++)
      if (!failed || dv[k]) mask[k] = 1'b1;
    r = '0;
    r.retired_block  = win_block[b];
    r.data_missing   = dmc[5:0];
    r.data_corrupt   = dcc[5:0];
    r.fec_missing    = fm[5:0];
    r.fec_corrupt    = fc[5:0];
    r.recon_failed   = failed;
    r.data_emit_mask = mask;
    r.restart_count  = restarts;
    r.last           = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic file_packet(in_item_t pkt);
    int          nd, nf, nb, pick;
    logic [31:0] blk, span;
    int          slot;
    bit          restart, found;
    nd = clamp(int'(reg_data), 1, MAX_PER_SIDE);
    nf = clamp(int'(reg_fec), 0, MAX_PER_SIDE);
    nb = clamp(int'(reg_bufs), 1, MAX_BUFFERS);
    span = nd + nf;
    blk  = pkt.seq_no / span;
    slot = int'(pkt.seq_no % span);
    restart = (longint'(blk) + longint'(RESTART_SPAN) * nb) < top_block;
    if ((longint'(blk) > top_block || restart) && pkt.crc_ok) begin
      // A restart empties the whole window without retiring anything.
      if (restart) begin
        restarts++;
        for (int i = 0; i < nb; i++) begin
          win_used[i]  = 0;
          win_block[i] = '0;
          clear_slots(i);
        end
      end
      pick  = 0;
      found = 0;
      for (int i = 0; i < nb && !found; i++)
        if (!win_used[i]) begin
          pick  = i;
          found = 1;
        end
      if (!found) begin
        for (int i = 1; i < nb; i++)
          if (win_block[i] < win_block[pick]) pick = i;
        retire_block(pick, nd, nf);
        clear_slots(pick);
      end
      win_block[pick] = blk;
      win_used[pick]  = 1;
      top_block       = longint'(blk);
    end
    found = 0;
    for (int i = 0; i < nb && !found; i++)
      if (win_used[i] && win_block[i] == blk) begin
        found = 1;
        if (!slot_good[i][slot]) begin
          slot_rx[i][slot]   = 1;
          slot_good[i][slot] = pkt.crc_ok;
        end
      end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_checked++;
    if (due_results.size() == 0) begin
      $error("result transaction with none due (block 0x%0h)", got.retired_block);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      check_field("retired_block", want.retired_block, got.retired_block);
      check_field("erased_data_index", want.erased_data_index, got.erased_data_index);
      check_field("fec_index", want.fec_index, got.fec_index);
      check_field("data_missing", want.data_missing, got.data_missing);
      check_field("data_corrupt", want.data_corrupt, got.data_corrupt);
      check_field("fec_missing", want.fec_missing, got.fec_missing);
      check_field("fec_corrupt", want.fec_corrupt, got.fec_corrupt);
      check_field("recon_failed", want.recon_failed, got.recon_failed);
      check_field("data_emit_mask", want.data_emit_mask, got.data_emit_mask);
      check_field("restart_count", want.restart_count, got.restart_count);
      check_field("last", want.last, got.last);
    end
  endtask

  initial begin
    fail_count      = 0;
    results_checked = 0;
    results_due     = 0;
    reset_window();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_window();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DATA_PER_BLOCK: reg_data = cfg_data[5:0];
          CFG_FEC_PER_BLOCK:  reg_fec  = cfg_data[5:0];
          CFG_BUFFERS_IN_USE: reg_bufs = cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) check_result(out_data);
      if (in_push && !in_full) file_packet(in_data);
    end
    results_due = due_results.size();
  end

endmodule

### tb/sv/tb_fec_block_window_reassembler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fec_block_window_reassembler: top of the window reassembler bench
// Drives packet transactions through several register settings, pops the
// results with random stalls and leaves all checking to the scoreboard.
// ----------------------------------------------------------------------------
module tb_fec_block_window_reassembler;
  import fbw_pkg::*;

  // Register index that the block must ignore.
  localparam logic [7:0] CFG_NO_SUCH_REG = 8'd3;
  // Longest run of cycles without any transaction before giving up. The
  // settling pause before register writes is far shorter than this.
  localparam int STALL_LIMIT = 20000;
  // Settling time after the last expected result; covers the divider, a
  // full window scan and a complete retirement of the largest block.
  localparam int SETTLE_CYCLES = 300;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  int fail_count;
  int results_due;
  int results_checked;
  int packets_sent;
  int idle_cycles;
  bit no_gaps;
  bit run_done;

  fec_block_window_reassembler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbw_scoreboard checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data         (in_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The result side stalls in roughly 15 percent of cycles, except during
  // the phase that runs without any gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= no_gaps || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (!run_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction", STALL_LIMIT);
        $display("tb_fec_block_window_reassembler: done, errors");
        $finish;
      end
    end
  end

  // Sends one packet transaction; push stays high into the next packet unless
  // a gap is drawn, so it is never lowered and raised in one time step.
  task automatic send_packet(logic [31:0] seq, logic crc);
    int gap;
    if (!no_gaps && $urandom_range(99) < 15) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 5);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{seq_no: seq, crc_ok: crc};
    @(posedge clk);
    while (in_full) @(posedge clk);
    packets_sent++;
  endtask

  // Waits until every predicted result has been popped, then lets the block
  // finish any packet that produces no result.
  task automatic wait_idle();
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all registers back to back, plus the ignored index, with valid
  // held high across the writes and lowered once at the end.
  task automatic write_regs(logic [7:0] d, logic [7:0] f, logic [7:0] b);
    logic [7:0] idx[4];
    logic [7:0] val[4];
    idx = '{CFG_DATA_PER_BLOCK, CFG_FEC_PER_BLOCK, CFG_BUFFERS_IN_USE, CFG_NO_SUCH_REG};
    val = '{d, f, b, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Directed packets for the default-like setting of 8 data, 4 FEC and two
  // buffers (12 slots a block).
  task automatic directed_packets();
    // Block 0 with a lost data slot, a bad data slot and a bad FEC slot.
    for (int s = 0; s < 12; s++)
      if (s != 2) send_packet(32'(s), !(s == 4 || s == 5));
    send_packet(32'd4, 1'b1);   // late good copy repairs a bad slot
    send_packet(32'd4, 1'b0);   // slot already good, ignored
    send_packet(32'd12, 1'b1);  // block 1 takes the free buffer
    send_packet(32'd24, 1'b0);  // new block with bad checksum: dropped
    send_packet(32'd24, 1'b1);  // block 2 retires block 0
    send_packet(32'hFFFF_FFFF, 1'b1);  // top of the range retires block 1
    send_packet(32'd7, 1'b0);   // far below but bad checksum: no restart
    send_packet(32'd7, 1'b1);   // transmitter restart clears the window
  endtask

  // Random packets: mostly a steady sequence with losses and bad checksums,
  // plus stale copies, forward jumps, restarts and fully random numbers.
  task automatic random_packets(int count, int span);
    logic [31:0] seq;
    int          pick;
    seq = $urandom_range(0, 4 * span);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        seq = seq + 1 + (($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
        send_packet(seq, $urandom_range(9) != 0);
      end else if (pick < 78) begin
        send_packet(seq - $urandom_range(0, 2 * span), 1'($urandom_range(1)));
      end else if (pick < 84) begin
        seq = seq + $urandom_range(span, 4 * span);
        send_packet(seq, 1'b1);
      end else if (pick < 88) begin
        seq = $urandom_range(0, 3 * span);
        send_packet(seq, $urandom_range(3) != 0);
      end else if (pick < 93) begin
        seq = $urandom;
        send_packet(seq, 1'b1);
      end else begin
        send_packet($urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(int d, int f, int b, int count, bit steady);
    wait_idle();
    write_regs(8'(d), 8'(f), 8'(b));
    no_gaps = steady;
    random_packets(count, ((d < 1 ? 1 : d) > 32 ? 32 : (d < 1 ? 1 : d)) + (f > 32 ? 32 : f));
    in_push <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_cycles  = 0;
    packets_sent = 0;
    no_gaps      = 1'b0;
    run_done     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs(8'd8, 8'd4, 8'd2);
    directed_packets();
    in_push <= 1'b0;

    // Smallest block, no FEC, single buffer.
    run_phase(1, 0, 1, 40, 1'b0);
    // Largest block and window, run without gaps on either side.
    run_phase(32, 32, 16, 45, 1'b1);
    // Out-of-range values that the block clamps (1 data, 32 FEC, 16 buffers).
    run_phase(0, 63, 31, 40, 1'b0);
    run_phase(3, 2, 0, 50, 1'b0);
    run_phase(8, 4, 4, 50, 1'b0);
    run_phase(5, 7, 3, 40, 1'b0);

    wait_idle();
    run_done = 1'b1;
    $display("Covered %0d packet transactions over seven register settings,",
             packets_sent);
    $display("with %0d result transactions checked.", results_checked);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb_fec_block_window_reassembler: done, clean");
    end else begin
      if (results_due != 0) $error("%0d expected results never arrived", results_due);
      $display("tb_fec_block_window_reassembler: done, errors");
    end
    $finish;
  end

endmodule
